// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the deframer design file.
// Each macro checks a condition on the rising clock edge, with reset masking it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every edge outside reset.
`define ASSERT_CHECK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property does not hold");

// The condition must never be true at an edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_CHECK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- design/kfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS deframer package
// Framing codes, field types and the controller state type.
// ----------------------------------------------------------------------------
package kfd_pkg;

  localparam int BYTE_W = 8;
  localparam int NIB_W  = 4;
  localparam int LEN_W  = 6;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [NIB_W-1:0]  nibble_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam byte_t CODE_FEND  = 8'hC0;
  localparam byte_t CODE_FESC  = 8'hDB;
  localparam byte_t CODE_TFEND = 8'hDC;
  localparam byte_t CODE_TFESC = 8'hDD;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_HDR
  } kfd_state_t;

endpackage

// ----- design/kfd_byte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS deframer input channel
// Valid/ready channel carrying one received serial byte per transfer.
// ----------------------------------------------------------------------------
interface kfd_byte_if;
  import kfd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- design/kfd_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS deframer result channel
// Valid/ready channel carrying one decoded frame result per transfer.
// ----------------------------------------------------------------------------
interface kfd_result_if;
  import kfd_pkg::*;

  logic    valid;
  logic    ready;
  nibble_t port_num;
  nibble_t command_code;
  len_t    payload_length;
  logic    has_data;
  byte_t   data_byte;
  logic    last_of_frame;

  modport source (
    output valid, output port_num, output command_code, output payload_length,
    output has_data, output data_byte, output last_of_frame, input ready
  );
  modport sink (
    input valid, input port_num, input command_code, input payload_length,
    input has_data, input data_byte, input last_of_frame, output ready
  );
endinterface

// ----- design/kfd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/kiss_frame_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame deframer
// Undoes KISS framing and escaping and plays each closed frame out as results,
// one per payload byte read back from the frame buffer RAM, or one header-only result.
// ----------------------------------------------------------------------------
// Throughput: one received byte per cycle while no frame is being played out.
// A closing FEND starts playout: each payload byte is read from the RAM in FETCH,
// then loaded into the output register in LOAD once that register is free.
// The input is held off until playout ends; a header-only frame holds it off
// while its result is loaded from HDR, which also waits for a free register.
// Synchronous reset puts the block outside any frame; the RAM is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kiss_frame_deframer #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic   clk,
  input  logic   rst,
  kfd_byte_if.sink     rx,
  kfd_result_if.source res
);
  import kfd_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);

  kfd_state_t state, state_next;

  logic              in_frame;
  logic              escape_pending;
  logic [CNT_W-1:0]  fill_count;
  byte_t             header;
  logic [ADDR_W-1:0] plen;
  logic [ADDR_W-1:0] rd_idx;

  logic    out_valid;
  nibble_t out_port;
  nibble_t out_cmd;
  len_t    out_len;
  logic    out_has_data;
  byte_t   out_data;
  logic    out_last;

  logic  in_acc;
  logic  is_fend;
  logic  frame_close;
  logic  do_store;
  logic  buf_full;
  logic  out_free;
  logic  rd_en;
  logic  load_data;
  logic  load_hdr;
  logic  at_last;
  byte_t store_byte;
  byte_t rd_data;

  assign in_acc   = rx.valid && rx.ready;
  assign is_fend  = (rx.rx_byte == CODE_FEND);
  assign frame_close = in_acc && is_fend && in_frame && (fill_count != '0);
  assign do_store = in_acc && !is_fend && in_frame &&
                    (escape_pending || (rx.rx_byte != CODE_FESC));
  assign buf_full = (fill_count == CNT_W'(BUFFER_BYTES));
  assign out_free = !out_valid || res.ready;
  assign at_last  = (rd_idx == plen);

  // An escaped TFEND or TFESC maps back to its code; anything else is kept.
  always_comb begin
    store_byte = rx.rx_byte;
    if (escape_pending) begin
      if (rx.rx_byte == CODE_TFEND) begin
        store_byte = CODE_FEND;
      end else if (rx.rx_byte == CODE_TFESC) begin
        store_byte = CODE_FESC;
      end
    end
  end

  kfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (do_store && !buf_full),
    .wr_addr (fill_count[ADDR_W-1:0]),
    .wr_data (store_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (frame_close) begin
          state_next = (fill_count == CNT_W'(1)) ? ST_HDR : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = at_last ? ST_IDLE : ST_FETCH;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    rx.ready  = 1'b0;
    rd_en     = 1'b0;
    load_data = 1'b0;
    load_hdr  = 1'b0;
    case (state)
      ST_IDLE:  rx.ready  = 1'b1;
      ST_FETCH: rd_en     = 1'b1;
      ST_LOAD:  load_data = out_free;
      ST_HDR:   load_hdr  = out_free;
      default: begin
        rx.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      fill_count     <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (is_fend) begin
          in_frame       <= 1'b1;
          escape_pending <= 1'b0;
          fill_count     <= '0;
        end else if (in_frame) begin
          if (escape_pending) begin
            escape_pending <= 1'b0;
          end else if (rx.rx_byte == CODE_FESC) begin
            escape_pending <= 1'b1;
          end
          if (do_store) begin
            if (buf_full) begin
              // Overflow drops the frame until the next FEND.
              in_frame       <= 1'b0;
              escape_pending <= 1'b0;
              fill_count     <= '0;
            end else begin
              fill_count <= fill_count + CNT_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_store && !buf_full && (fill_count == '0)) begin
      header <= store_byte;
    end
    if (frame_close) begin
      plen   <= ADDR_W'(fill_count - CNT_W'(1));
      rd_idx <= ADDR_W'(1);
    end else if (load_data) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  // Output register: the input side is free again while the last result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_data || load_hdr) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_data) begin
      out_port     <= header[7:4];
      out_cmd      <= header[3:0];
      out_len      <= LEN_W'(plen);
      out_has_data <= 1'b1;
      out_data     <= rd_data;
      out_last     <= at_last;
    end else if (load_hdr) begin
      out_port     <= header[7:4];
      out_cmd      <= header[3:0];
      out_len      <= '0;
      out_has_data <= 1'b0;
      out_data     <= '0;
      out_last     <= 1'b1;
    end
  end

  assign res.valid          = out_valid;
  assign res.port_num       = out_port;
  assign res.command_code   = out_cmd;
  assign res.payload_length = out_len;
  assign res.has_data       = out_has_data;
  assign res.data_byte      = out_data;
  assign res.last_of_frame  = out_last;

  `ASSERT_NEVER(a_fill_bound, clk, rst, fill_count > CNT_W'(BUFFER_BYTES))
  `ASSERT_NEVER(a_playout_clean, clk, rst, (state != ST_IDLE) && ((fill_count != '0) || !in_frame))
  `ASSERT_NEVER(a_rd_idx_range, clk, rst, (state == ST_FETCH) && ((rd_idx == '0) || (rd_idx > plen)))
  `ASSERT_CHECK(a_last_ends_run, clk, rst, (load_data && at_last) |=> (state == ST_IDLE) && res.last_of_frame)
  `ASSERT_CHECK(a_close_starts_run, clk, rst, frame_close |=> (state == ST_FETCH) || (state == ST_HDR))

endmodule

// ----- test/kiss_frame_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame deframer testbench
// Drives received bytes into the deframer and predicts each decoded frame
// byte in a behavioral model that keeps its own framing state and buffer.
// Directed framing and escape cases come first, then random frame traffic
// with idle phases on the input and stall phases on the output.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_tb;
  import kfd_pkg::*;

  localparam int BUF_BYTES     = 64;
  localparam int PHASE_ITEMS   = 32;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    nibble_t port_num;
    nibble_t command_code;
    len_t    payload_length;
    logic    has_data;
    byte_t   data_byte;
    logic    last_of_frame;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst;

  kfd_byte_if   rx_if ();
  kfd_result_if res_if ();

  kiss_frame_deframer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .res(res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Deframing state of the behavioral model.
  bit          in_frm;
  bit          esc_pend;
  int unsigned fill_cnt;
  byte_t       frm_buf [BUF_BYTES];

  frame_byte_t frame_bytes_q[$];
  int unsigned mismatches;
  int unsigned rx_accepted;
  int unsigned idle_pct;
  int unsigned stall_pct;

  function automatic void deframe_rx_byte(byte_t b);
    frame_byte_t r;
    byte_t       v;
    int unsigned plen;
    if (b == CODE_FEND) begin
      if (in_frm && fill_cnt > 0) begin
        plen           = fill_cnt - 1;
        r.port_num     = frm_buf[0][7:4];
        r.command_code = frm_buf[0][3:0];
        if (plen == 0) begin
          r.payload_length = '0;
          r.has_data       = 1'b0;
          r.data_byte      = '0;
          r.last_of_frame  = 1'b1;
          frame_bytes_q.push_back(r);
        end else begin
          for (int i = 0; i < plen; i++) begin
            r.payload_length = len_t'(plen);
            r.has_data       = 1'b1;
            r.data_byte      = frm_buf[i + 1];
            r.last_of_frame  = (i + 1 == plen);
            frame_bytes_q.push_back(r);
          end
        end
      end
      in_frm   = 1'b1;
      esc_pend = 1'b0;
      fill_cnt = 0;
      return;
    end
    if (!in_frm) return;
    v = b;
    if (esc_pend) begin
      if (b == CODE_TFEND) v = CODE_FEND;
      else if (b == CODE_TFESC) v = CODE_FESC;
      esc_pend = 1'b0;
    end else if (b == CODE_FESC) begin
      esc_pend = 1'b1;
      return;
    end
    if (fill_cnt < BUF_BYTES) begin
      frm_buf[fill_cnt] = v;
      fill_cnt++;
    end else begin
      // The frame no longer fits: drop it and wait for the next FEND.
      in_frm   = 1'b0;
      esc_pend = 1'b0;
      fill_cnt = 0;
    end
  endfunction

  task automatic send_byte(input byte_t b);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    rx_accepted++;
    deframe_rx_byte(b);
  endtask

  task automatic wait_results_drained();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (frame_bytes_q.size() != 0);
  endtask

  // Sends one buffer byte with the escaping a well-formed sender would use,
  // and now and then an escape of a byte that needs none.
  task automatic send_stuffed(input byte_t v);
    if (v == CODE_FEND) begin
      send_byte(CODE_FESC);
      send_byte(CODE_TFEND);
    end else if (v == CODE_FESC) begin
      send_byte(CODE_FESC);
      send_byte(CODE_TFESC);
    end else if (v != CODE_TFEND && v != CODE_TFESC && $urandom_range(0, 99) < 5) begin
      send_byte(CODE_FESC);
      send_byte(v);
    end else begin
      send_byte(v);
    end
  endtask

  function automatic byte_t random_frame_byte();
    byte_t codes [4];
    codes = '{CODE_FEND, CODE_FESC, CODE_TFEND, CODE_TFESC};
    if ($urandom_range(0, 99) < 15) return codes[$urandom_range(0, 3)];
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input int unsigned data_len, input bit with_open);
    if (with_open) send_byte(CODE_FEND);
    send_stuffed(byte_t'($urandom_range(0, 255)));
    for (int i = 0; i < data_len; i++) send_stuffed(random_frame_byte());
    send_byte(CODE_FEND);
  endtask

  task automatic test_frame_marks();
    // Bytes before any FEND are ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CODE_FESC);
    send_byte(CODE_TFEND);
    // Opening FEND, then an empty frame.
    send_byte(CODE_FEND);
    send_byte(CODE_FEND);
    // Header-only frame with both nibbles at their maximum.
    send_byte(8'hFF);
    send_byte(CODE_FEND);
    // Header with both nibbles zero and data at both extremes.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CODE_FEND);
  endtask

  task automatic test_escaping();
    send_byte(8'h5A);
    send_byte(CODE_FESC);
    send_byte(CODE_TFEND);
    send_byte(CODE_FESC);
    send_byte(CODE_TFESC);
    // Escaped bytes that are not transposed codes are stored unchanged.
    send_byte(CODE_FESC);
    send_byte(8'h41);
    send_byte(CODE_FESC);
    send_byte(CODE_FESC);
    send_byte(CODE_FEND);
    // A FEND right after FESC still closes the frame.
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(CODE_FESC);
    send_byte(CODE_FEND);
  endtask

  task automatic test_random_frames();
    int unsigned idle_sched  [4];
    int unsigned stall_sched [4];
    int unsigned start_cnt;
    int unsigned pick;
    int unsigned nframes;
    bit          need_open;
    idle_sched  = '{0, 85, 0, 17};
    stall_sched = '{0, 0, 85, 17};
    need_open   = 1'b1;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_sched[p];
      stall_pct = stall_sched[p];
      start_cnt = rx_accepted;
      nframes   = 0;
      while (rx_accepted - start_cnt < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if ((p == 0 && nframes == 0) || (p == 2 && nframes == 0)) begin
          // Fills the buffer exactly: header plus the longest payload.
          send_frame(BUF_BYTES - 1, need_open);
          need_open = 1'b0;
        end else if ((p == 0 && nframes == 1) || pick < 2) begin
          // One stored byte too many: the frame is dropped at its last byte, and
          // its closing FEND yields no result.
          send_frame(BUF_BYTES, 1'b1);
          send_frame($urandom_range(0, 4), 1'b1);
          need_open = 1'b0;
        end else if (pick < 10) begin
          for (int i = $urandom_range(1, 6); i > 0; i--)
            send_byte(byte_t'($urandom_range(0, 255)));
          need_open = 1'b1;
        end else if (pick < 16) begin
          if (need_open) send_byte(CODE_FEND);
          for (int i = $urandom_range(0, 3); i > 0; i--)
            send_byte(byte_t'($urandom_range(0, 255)));
          send_byte(CODE_FESC);
          send_byte(CODE_FEND);
          need_open = 1'b0;
        end else begin
          send_frame($urandom_range(0, 12), need_open || $urandom_range(0, 1));
          need_open = 1'b0;
        end
        nframes++;
      end
      wait_results_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (frame_bytes_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual port %0h cmd %0h len %0d data %0h",
                 $time, res_if.port_num, res_if.command_code, res_if.payload_length,
                 res_if.data_byte);
        mismatches++;
      end else begin
        want = frame_bytes_q.pop_front();
        compare_field("port_num", byte_t'(want.port_num), byte_t'(res_if.port_num));
        compare_field("command_code", byte_t'(want.command_code),
                      byte_t'(res_if.command_code));
        compare_field("payload_length", byte_t'(want.payload_length),
                      byte_t'(res_if.payload_length));
        compare_field("has_data", byte_t'(want.has_data), byte_t'(res_if.has_data));
        compare_field("data_byte", want.data_byte, res_if.data_byte);
        compare_field("last_of_frame", byte_t'(want.last_of_frame),
                      byte_t'(res_if.last_of_frame));
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    in_frm        = 1'b0;
    esc_pend      = 1'b0;
    fill_cnt      = 0;
    mismatches    = 0;
    rx_accepted   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_frame_marks();
    test_escaping();
    wait_results_drained();
    test_random_frames();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
